// ===== rtl/mean_nearest_neighbour_sigma_macros.svh =====
// assertion helpers shared by mnns_front, mnns_fifo and mnns_back
`ifndef MEAN_NEAREST_NEIGHBOUR_SIGMA_MACROS_SVH
`define MEAN_NEAREST_NEIGHBOUR_SIGMA_MACROS_SVH

// same-cycle implication
`define MNNS_ASSERT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mnns assertion failed");

// next-cycle implication
`define MNNS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mnns assertion failed");

`endif

// ===== rtl/mnns_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mnns_pkg;
	localparam int COORD_W = 16;
	localparam int SSD_W = 37;
	localparam int SUM_W = 43;
	localparam int SIGMA_W = 27;
	localparam int MODE_W = 2;
	localparam int VCOUNT_W = 7;
	localparam int DIM_W = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 7;

	localparam int DEF_MAX_VECTORS = 64;
	localparam int DEF_MAX_DIM = 16;

	// field widths sized for the largest allowed parameter values
	localparam int VIDX_W = 10;
	localparam int ADDR_W = 18;
	localparam int CNT_W = 11;
	localparam int DCNT_W = 9;

	localparam int ISQ_W = 60;
	localparam int ROOT_W = 30;
	localparam int DVD_W = SUM_W + 16;
	localparam int SCALE_W = 24;
	localparam int CMD_DEPTH = 2;

	localparam logic [SSD_W-1:0] SSD_MAX = '1;
	// 1/sqrt(2 ln 2) in q0.24
	localparam logic [SCALE_W-1:0] INV_HALFMAX = 24'd14249255;

	localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VCOUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIM = 2'd2;

	localparam logic [MODE_W-1:0] MODE_MEAN = 2'd0;
	localparam logic [MODE_W-1:0] MODE_HALFMAX = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RMS = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RMS_SCALED = 2'd3;

	typedef struct packed {
		logic [VIDX_W-1:0] vec;
		logic [ADDR_W-1:0] base;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [CNT_W-1:0] count;
		logic [DCNT_W-1:0] dim;
	} cfg_t;

	typedef struct packed {
		logic en;
		logic [ADDR_W-1:0] addr;
		logic [COORD_W-1:0] data;
	} store_wr_t;
endpackage
`default_nettype wire

// ===== rtl/mnns_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mnns_isqrt (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [mnns_pkg::ISQ_W-1:0] x,
	output logic busy,
	output logic done,
	output logic [mnns_pkg::ROOT_W-1:0] root
);
	import mnns_pkg::*;

	localparam int R_W = ROOT_W + 3;
	localparam int C_W = $clog2(ROOT_W + 1);

	logic [ISQ_W-1:0] x_q;
	logic [R_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [C_W-1:0] cnt_q;
	logic busy_q, done_q;
	logic [R_W-1:0] rem_sh, trial;
	logic ge;

	// two bits of the radicand per cycle
	assign rem_sh = {rem_q[R_W-3:0], x_q[ISQ_W-1 -: 2]};
	assign trial = R_W'({root_q, 2'b01});
	assign ge = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= C_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == C_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x;
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[ISQ_W-3:0], 2'b00};
			if (ge) begin
				rem_q <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

// ===== rtl/mnns_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mnns_div #(
	parameter int NW = 7
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [mnns_pkg::DVD_W-1:0] dividend,
	input wire logic [NW-1:0] divisor,
	output logic busy,
	output logic done,
	output logic [mnns_pkg::DVD_W-1:0] quotient
);
	import mnns_pkg::*;

	localparam int C_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] q_q;
	logic [NW-1:0] rem_q, div_q;
	logic [C_W-1:0] cnt_q;
	logic busy_q, done_q;
	logic [NW:0] rem_sh;
	logic ge;

	// restoring division, one quotient bit per cycle
	assign rem_sh = {rem_q, q_q[DVD_W-1]};
	assign ge = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= C_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == C_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= NW'(rem_sh - {1'b0, div_q});
				q_q <= {q_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[NW-1:0];
				q_q <= {q_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = q_q;
endmodule
`default_nettype wire

// ===== rtl/mnns_front.sv =====
`timescale 1ns / 1ps
`include "mean_nearest_neighbour_sigma_macros.svh"
`default_nettype none
module mnns_front #(
	parameter int MAX_VECTORS = 64,
	parameter int MAX_DIM = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic signed [mnns_pkg::COORD_W-1:0] coordinate,
	input wire logic cfg_we,
	input wire logic [mnns_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [mnns_pkg::CFG_DATA_W-1:0] cfg_data,
	output mnns_pkg::cfg_t cfg,
	output logic clear,
	output mnns_pkg::store_wr_t store_wr,
	output logic cmd_push,
	output mnns_pkg::cmd_t cmd,
	input wire logic cmd_full,
	input wire logic set_done
);
	import mnns_pkg::*;

	localparam int NW = $clog2(MAX_VECTORS + 1);
	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int VW = $clog2(MAX_VECTORS);
	localparam int KW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int AW = $clog2(MAX_VECTORS * MAX_DIM);

	logic [MODE_W-1:0] mode_q;
	logic [VCOUNT_W-1:0] vcount_q;
	logic [DIM_W-1:0] dim_q;
	logic [KW-1:0] k_q;
	logic [VW-1:0] v_q;
	logic [AW-1:0] wa_q, base_q;
	logic hold_q;
	logic cfg_hit, accept, end_vec, last_vec;
	logic [31:0] n32, d32;
	logic [NW-1:0] n_eff;
	logic [DW-1:0] d_eff;

	// out-of-range counts are clamped
	always_comb begin
		if (32'(vcount_q) < 32'd2)
			n32 = 32'd2;
		else if (32'(vcount_q) > 32'(MAX_VECTORS))
			n32 = 32'(MAX_VECTORS);
		else
			n32 = 32'(vcount_q);
		if (dim_q == '0)
			d32 = 32'd1;
		else if (32'(dim_q) > 32'(MAX_DIM))
			d32 = 32'(MAX_DIM);
		else
			d32 = 32'(dim_q);
	end
	assign n_eff = n32[NW-1:0];
	assign d_eff = d32[DW-1:0];

	assign cfg_hit = cfg_we && (cfg_index inside {REG_MODE, REG_VCOUNT, REG_DIM});
	assign full = cmd_full || hold_q;
	assign accept = push && !full;
	assign end_vec = (32'(k_q) + 32'd1) == 32'(d_eff);
	assign last_vec = (32'(v_q) + 32'd1) == 32'(n_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_MEAN;
			vcount_q <= VCOUNT_W'(64);
			dim_q <= DIM_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE: mode_q <= cfg_data[MODE_W-1:0];
				REG_VCOUNT: vcount_q <= cfg_data[VCOUNT_W-1:0];
				REG_DIM: dim_q <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			v_q <= '0;
			wa_q <= '0;
			base_q <= '0;
			hold_q <= 1'b0;
		end else if (cfg_hit) begin
			k_q <= '0;
			v_q <= '0;
			wa_q <= '0;
			base_q <= '0;
			hold_q <= 1'b0;
		end else if (accept) begin
			if (end_vec) begin
				k_q <= '0;
				if (last_vec) begin
					// new set waits until the back end has finished this one
					v_q <= '0;
					wa_q <= '0;
					base_q <= '0;
					hold_q <= 1'b1;
				end else begin
					v_q <= v_q + 1'b1;
					wa_q <= wa_q + 1'b1;
					base_q <= wa_q + 1'b1;
				end
			end else begin
				k_q <= k_q + 1'b1;
				wa_q <= wa_q + 1'b1;
			end
		end else if (set_done) begin
			hold_q <= 1'b0;
		end
	end

	assign store_wr.en = accept;
	assign store_wr.addr = ADDR_W'(wa_q);
	assign store_wr.data = coordinate;

	assign cmd_push = accept && end_vec;
	assign cmd.vec = VIDX_W'(v_q);
	assign cmd.base = ADDR_W'(base_q);
	assign cmd.last = last_vec;

	assign cfg.mode = mode_q;
	assign cfg.count = CNT_W'(n_eff);
	assign cfg.dim = DCNT_W'(d_eff);
	assign clear = cfg_hit;

	`MNNS_ASSERT_NEXT(a_hold_after_last, clk, arst_n, cmd_push && cmd.last && !cfg_hit, hold_q)
	`MNNS_ASSERT(a_no_cmd_while_held, clk, arst_n, hold_q, !cmd_push)
endmodule
`default_nettype wire

// ===== rtl/mnns_fifo.sv =====
`timescale 1ns / 1ps
`include "mean_nearest_neighbour_sigma_macros.svh"
`default_nettype none
module mnns_fifo (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic clear,
	input wire logic push,
	input wire mnns_pkg::cmd_t din,
	output logic full,
	input wire logic pop,
	output mnns_pkg::cmd_t dout,
	output logic empty
);
	import mnns_pkg::*;

	localparam int PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;

	cmd_t mem_q [CMD_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0] cnt_q;
	logic do_push, do_pop;

	assign full = cnt_q == (PW + 1)'(CMD_DEPTH);
	assign empty = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign dout = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else if (clear) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wp_q <= wp_q + 1'b1;
			if (do_pop)
				rp_q <= rp_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wp_q] <= din;
	end

	`MNNS_ASSERT(a_no_overflow, clk, arst_n, push, !full)
	`MNNS_ASSERT(a_no_underflow, clk, arst_n, pop, !empty)
endmodule
`default_nettype wire

// ===== rtl/mnns_back.sv =====
`timescale 1ns / 1ps
`include "mean_nearest_neighbour_sigma_macros.svh"
`default_nettype none
module mnns_back #(
	parameter int MAX_VECTORS = 64,
	parameter int MAX_DIM = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire mnns_pkg::cfg_t cfg,
	input wire logic clear,
	input wire mnns_pkg::store_wr_t store_wr,
	input wire logic cmd_empty,
	input wire mnns_pkg::cmd_t cmd,
	output logic cmd_pop,
	output logic set_done,
	output logic empty,
	input wire logic pop,
	output logic [mnns_pkg::SIGMA_W-1:0] sigma
);
	import mnns_pkg::*;

	localparam int NW = $clog2(MAX_VECTORS + 1);
	localparam int VW = $clog2(MAX_VECTORS);
	localparam int KW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DEPTH = MAX_VECTORS * MAX_DIM;
	localparam int AW = $clog2(DEPTH);
	localparam int ACC_RAW = 2 * COORD_W + KW + 1;
	localparam int ACC_W = (ACC_RAW > SSD_W) ? ACC_RAW : SSD_W + 1;
	localparam int PROD_W = SIGMA_W + SCALE_W;

	typedef enum logic [14:0] {
		S_IDLE   = 15'b000000000000001,
		S_RUN    = 15'b000000000000010,
		S_DRAIN  = 15'b000000000000100,
		S_NRD    = 15'b000000000001000,
		S_NCMP   = 15'b000000000010000,
		S_NVW    = 15'b000000000100000,
		S_FRD    = 15'b000000001000000,
		S_FGET   = 15'b000000010000000,
		S_FSQ    = 15'b000000100000000,
		S_DSTART = 15'b000001000000000,
		S_DWAIT  = 15'b000010000000000,
		S_RSTART = 15'b000100000000000,
		S_RWAIT  = 15'b001000000000000,
		S_SCALE  = 15'b010000000000000,
		S_OUT    = 15'b100000000000000
	} state_t;

	state_t st_q;
	logic signed [COORD_W-1:0] store_mem [DEPTH];
	logic [SSD_W-1:0] nearest_mem [MAX_VECTORS];
	logic [MAX_VECTORS-1:0] nvalid_q;

	logic [VW-1:0] vec_q, j_q;
	logic last_q;
	logic [AW-1:0] base_q, addr_b_q, addr_a;
	logic [KW-1:0] k_q;
	logic vld_s1, vld_s2;
	logic signed [COORD_W-1:0] a_s1, b_s1;
	logic [2*COORD_W-1:0] sq_s2;
	logic signed [COORD_W:0] diff;
	logic [COORD_W-1:0] mag;
	logic [ACC_W-1:0] acc_q;
	logic [SSD_W-1:0] ssd_q, minv_q, ssd_sat, nval;
	logic [SSD_W-1:0] nrd_data_s1;
	logic nrd_vld_s1;
	logic [NW-1:0] i_q;
	logic [SUM_W-1:0] sum_q;
	logic [ROOT_W-1:0] res_q;
	logic [PROD_W-1:0] prod_q;
	logic out_valid_q;
	logic [SIGMA_W-1:0] sigma_q;

	logic rd_en, n_rd_en, n_wr_en;
	logic [VW-1:0] n_rd_addr, n_wr_addr;
	logic last_k, last_j, last_i, root_mode, out_wr;
	logic [SIGMA_W-1:0] sigma_nx;
	logic isq_start, isq_busy, isq_done;
	logic [ISQ_W-1:0] isq_x;
	logic [ROOT_W-1:0] isq_root;
	logic div_start, div_busy, div_done;
	logic [DVD_W-1:0] div_dvd, div_q;

	assign addr_a = base_q + AW'(k_q);
	assign last_k = (32'(k_q) + 32'd1) == 32'(cfg.dim);
	assign last_j = (32'(j_q) + 32'd1) == 32'(vec_q);
	assign last_i = (32'(i_q) + 32'd1) == 32'(cfg.count);
	assign root_mode = (cfg.mode == MODE_MEAN) || (cfg.mode == MODE_HALFMAX);
	assign ssd_sat = (acc_q > ACC_W'(SSD_MAX)) ? SSD_MAX : acc_q[SSD_W-1:0];
	// entries not written in this set read as all ones
	assign nval = nrd_vld_s1 ? nrd_data_s1 : SSD_MAX;

	assign rd_en = st_q == S_RUN;
	assign n_rd_en = (st_q == S_NRD) || (st_q == S_FRD);
	assign n_rd_addr = (st_q == S_NRD) ? j_q : i_q[VW-1:0];
	assign n_wr_en = ((st_q == S_NCMP) && (ssd_q < nval)) || (st_q == S_NVW);
	assign n_wr_addr = (st_q == S_NVW) ? vec_q : j_q;

	assign cmd_pop = (st_q == S_IDLE) && !cmd_empty;
	assign out_wr = (st_q == S_OUT) && (!out_valid_q || pop);
	assign set_done = out_wr;

	assign isq_start = ((st_q == S_FGET) && root_mode) || (st_q == S_RSTART);
	assign isq_x = (st_q == S_RSTART) ? ISQ_W'(div_q) : ISQ_W'({nval, 16'b0});
	assign div_start = st_q == S_DSTART;
	assign div_dvd = root_mode ? DVD_W'(sum_q) : {sum_q, 16'b0};

	assign sigma_nx = (cfg.mode == MODE_HALFMAX) ? prod_q[SCALE_W +: SIGMA_W]
		: res_q[SIGMA_W-1:0];

	assign diff = {a_s1[COORD_W-1], a_s1} - {b_s1[COORD_W-1], b_s1};
	assign mag = diff[COORD_W] ? COORD_W'(-diff) : COORD_W'(diff);

	// coordinate store: one write from the front end, two reads
	always_ff @(posedge clk) begin
		if (store_wr.en)
			store_mem[store_wr.addr[AW-1:0]] <= store_wr.data;
		if (rd_en) begin
			a_s1 <= store_mem[addr_a];
			b_s1 <= store_mem[addr_b_q];
		end
	end

	always_ff @(posedge clk) begin
		if (n_wr_en)
			nearest_mem[n_wr_addr] <= (st_q == S_NVW) ? minv_q : ssd_q;
		if (n_rd_en)
			nrd_data_s1 <= nearest_mem[n_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (vld_s1)
			sq_s2 <= mag * mag;
		if (n_rd_en)
			nrd_vld_s1 <= nvalid_q[n_rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nvalid_q <= '0;
		end else if (clear || out_wr) begin
			nvalid_q <= '0;
		end else if (n_wr_en) begin
			nvalid_q[n_wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_wr) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_wr)
			sigma_q <= sigma_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else if (clear) begin
			st_q <= S_IDLE;
		end else begin
			case (st_q)
				S_IDLE: if (!cmd_empty && (cmd.vec != '0)) st_q <= S_RUN;
				S_RUN: if (last_k) st_q <= S_DRAIN;
				S_DRAIN: if (!vld_s1 && !vld_s2) st_q <= S_NRD;
				S_NRD: st_q <= S_NCMP;
				S_NCMP: st_q <= last_j ? S_NVW : S_RUN;
				S_NVW: st_q <= last_q ? S_FRD : S_IDLE;
				S_FRD: st_q <= S_FGET;
				S_FGET: begin
					if (root_mode)
						st_q <= S_FSQ;
					else
						st_q <= last_i ? S_DSTART : S_FRD;
				end
				S_FSQ: if (isq_done) st_q <= last_i ? S_DSTART : S_FRD;
				S_DSTART: st_q <= S_DWAIT;
				S_DWAIT: begin
					if (div_done) begin
						if (cfg.mode == MODE_MEAN)
							st_q <= S_OUT;
						else if (cfg.mode == MODE_HALFMAX)
							st_q <= S_SCALE;
						else
							st_q <= S_RSTART;
					end
				end
				S_RSTART: st_q <= S_RWAIT;
				S_RWAIT: if (isq_done) st_q <= S_OUT;
				S_SCALE: st_q <= S_OUT;
				S_OUT: if (out_wr) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers of the sequencer
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				vec_q <= cmd.vec[VW-1:0];
				base_q <= cmd.base[AW-1:0];
				last_q <= cmd.last;
				j_q <= '0;
				k_q <= '0;
				addr_b_q <= '0;
				acc_q <= '0;
				minv_q <= SSD_MAX;
			end
			S_RUN: begin
				k_q <= last_k ? '0 : k_q + 1'b1;
				addr_b_q <= addr_b_q + 1'b1;
				if (vld_s2)
					acc_q <= acc_q + ACC_W'(sq_s2);
			end
			S_DRAIN: begin
				if (vld_s2)
					acc_q <= acc_q + ACC_W'(sq_s2);
			end
			S_NRD: ssd_q <= ssd_sat;
			S_NCMP: begin
				if (ssd_q < minv_q)
					minv_q <= ssd_q;
				j_q <= j_q + 1'b1;
				acc_q <= '0;
			end
			S_NVW: begin
				i_q <= '0;
				sum_q <= '0;
			end
			S_FGET: begin
				if (!root_mode) begin
					sum_q <= sum_q + SUM_W'(nval);
					i_q <= i_q + 1'b1;
				end
			end
			S_FSQ: begin
				if (isq_done) begin
					sum_q <= sum_q + SUM_W'(isq_root);
					i_q <= i_q + 1'b1;
				end
			end
			S_DWAIT: if (div_done) res_q <= div_q[ROOT_W-1:0];
			S_RWAIT: begin
				if (isq_done) begin
					if (cfg.mode == MODE_RMS_SCALED)
						res_q <= isq_root + (isq_root >> 1);
					else
						res_q <= isq_root;
				end
			end
			S_SCALE: prod_q <= res_q[SIGMA_W-1:0] * INV_HALFMAX;
			default: ;
		endcase
	end

	mnns_isqrt u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(isq_start),
		.x(isq_x),
		.busy(isq_busy),
		.done(isq_done),
		.root(isq_root)
	);

	mnns_div #(.NW(NW)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dvd),
		.divisor(cfg.count[NW-1:0]),
		.busy(div_busy),
		.done(div_done),
		.quotient(div_q)
	);

	assign empty = !out_valid_q;
	assign sigma = sigma_q;

	`MNNS_ASSERT(a_div_start_idle, clk, arst_n, div_start, !div_busy)
	`MNNS_ASSERT(a_isq_start_idle, clk, arst_n, isq_start, !isq_busy)
endmodule
`default_nettype wire

// ===== rtl/mean_nearest_neighbour_sigma.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Mean nearest-neighbour kernel width. Coordinates (signed q8.8) arrive one item at a time,
// vector after vector; after the last coordinate of the set one sigma comes out, in units of
// the coordinate lsb / 256. The front end stores each coordinate as it is accepted; when a
// vector v is complete, the back end compares it with the v earlier vectors through the two
// read ports of the coordinate memory, while the front end keeps taking coordinates until the
// two-entry command queue is full. At the end of a set the back end walks the n minima, taking
// the square root of each in modes 0 and 1, then runs a bit-serial divider and, in modes 2 and
// 3, a bit-serial square root or, in mode 1, a scaling multiply; full stays high from the last
// coordinate until the sigma is in the output register. Writing any register aborts the set in
// progress; the user must write only while the block is idle, the block does not enforce it.
module mean_nearest_neighbour_sigma #(
	parameter int MAX_VECTORS = mnns_pkg::DEF_MAX_VECTORS,
	parameter int MAX_DIM = mnns_pkg::DEF_MAX_DIM
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	output logic full,
	input wire logic signed [mnns_pkg::COORD_W-1:0] coordinate,
	output logic empty,
	input wire logic pop,
	output logic [mnns_pkg::SIGMA_W-1:0] sigma,
	input wire logic cfg_we,
	input wire logic [mnns_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [mnns_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mnns_pkg::*;

	cfg_t cfg;
	store_wr_t store_wr;
	cmd_t cmd_in, cmd_out;
	logic clear, cmd_push, cmd_full, cmd_pop, cmd_empty, set_done;

	mnns_front #(.MAX_VECTORS(MAX_VECTORS), .MAX_DIM(MAX_DIM)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.coordinate(coordinate),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg),
		.clear(clear),
		.store_wr(store_wr),
		.cmd_push(cmd_push),
		.cmd(cmd_in),
		.cmd_full(cmd_full),
		.set_done(set_done)
	);

	mnns_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.clear(clear),
		.push(cmd_push),
		.din(cmd_in),
		.full(cmd_full),
		.pop(cmd_pop),
		.dout(cmd_out),
		.empty(cmd_empty)
	);

	mnns_back #(.MAX_VECTORS(MAX_VECTORS), .MAX_DIM(MAX_DIM)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.clear(clear),
		.store_wr(store_wr),
		.cmd_empty(cmd_empty),
		.cmd(cmd_out),
		.cmd_pop(cmd_pop),
		.set_done(set_done),
		.empty(empty),
		.pop(pop),
		.sigma(sigma)
	);
endmodule
`default_nettype wire

// ===== bench/tb_mean_nearest_neighbour_sigma.sv =====
`timescale 1ns / 1ps
module tb_mean_nearest_neighbour_sigma;
	import mnns_pkg::*;

	localparam int NVEC = DEF_MAX_VECTORS;
	localparam int NDIM = DEF_MAX_DIM;
	localparam int DEPTH = NVEC * NDIM;
	localparam logic [42:0] SUM_MASK = '1;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic signed [COORD_W-1:0] coordinate;
	logic empty;
	logic pop;
	logic [SIGMA_W-1:0] sigma;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mean_nearest_neighbour_sigma u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .coordinate(coordinate),
		.empty(empty), .pop(pop), .sigma(sigma), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic [MODE_W-1:0] kw_mode;
	logic [VCOUNT_W-1:0] kw_count;
	logic [DIM_W-1:0] kw_dim;
	logic signed [COORD_W-1:0] coord_mem [DEPTH];
	logic [SSD_W-1:0] min_ssd [NVEC];
	int unsigned fill_pos;

	logic signed [COORD_W-1:0] coord_queue [$];
	logic [SIGMA_W-1:0] sigma_queue [$];
	int errors;
	int sets_done;
	int cfg_writes;
	bit quiet;
	int send_gap;
	int pop_gap;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#300ms;
		$display("mean_nearest_neighbour_sigma regression: fail");
		$finish;
	end

	function automatic logic [63:0] int_sqrt(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic int unsigned used_count();
		if (kw_count < 2) return 2;
		if (kw_count > NVEC) return NVEC;
		return kw_count;
	endfunction

	function automatic int unsigned used_dim();
		if (kw_dim < 1) return 1;
		if (kw_dim > NDIM) return NDIM;
		return kw_dim;
	endfunction

	function automatic void restart_set();
		foreach (min_ssd[i]) min_ssd[i] = SSD_MAX;
		fill_pos = 0;
	endfunction

	function automatic logic [63:0] vector_ssd(int unsigned a, int unsigned b, int unsigned d);
		logic [63:0] s;
		int diff;
		s = 0;
		for (int unsigned k = 0; k < d; k++) begin
			diff = int'(coord_mem[(a * d + k) % DEPTH]) - int'(coord_mem[(b * d + k) % DEPTH]);
			if (diff < 0) diff = -diff;
			s += 64'(diff) * 64'(diff);
		end
		return (s > 64'(SSD_MAX)) ? 64'(SSD_MAX) : s;
	endfunction

	function automatic logic [63:0] kernel_width(int unsigned n);
		logic [42:0] acc;
		logic [63:0] w;
		acc = 0;
		if (kw_mode == MODE_MEAN || kw_mode == MODE_HALFMAX) begin
			for (int unsigned i = 0; i < n; i++)
				acc = (acc + 43'(int_sqrt(64'(min_ssd[i]) << 16))) & SUM_MASK;
			w = 64'(acc) / n;
			if (kw_mode == MODE_HALFMAX) w = (w * 64'(INV_HALFMAX)) >> 24;
		end else begin
			for (int unsigned i = 0; i < n; i++) acc = (acc + 43'(min_ssd[i])) & SUM_MASK;
			w = int_sqrt((64'(acc) << 16) / n);
			if (kw_mode == MODE_RMS_SCALED) w = (w * 3) >> 1;
		end
		return w;
	endfunction

	function automatic void take_coordinate(logic signed [COORD_W-1:0] c);
		int unsigned n, d, pos, v;
		logic [63:0] s;
		n = used_count();
		d = used_dim();
		pos = fill_pos % DEPTH;
		coord_mem[pos] = c;
		pos++;
		fill_pos = pos;
		if (pos % d != 0) return;
		v = pos / d - 1;
		if (v >= NVEC) v = NVEC - 1;
		for (int unsigned j = 0; j < v; j++) begin
			s = vector_ssd(v, j, d);
			if (s < 64'(min_ssd[v])) min_ssd[v] = SSD_W'(s);
			if (s < 64'(min_ssd[j])) min_ssd[j] = SSD_W'(s);
		end
		if (v + 1 < n) return;
		sigma_queue.push_back(SIGMA_W'(kernel_width(n)));
		restart_set();
	endfunction

	// accepted items go to the predictor
	always @(posedge clk) begin
		if (arst_n && push && !full) begin
			take_coordinate(coordinate);
			void'(coord_queue.pop_front());
		end
	end

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				push <= 1'b0;
			end else if (coord_queue.size() > 0) begin
				if (!quiet && $urandom_range(0, 9) == 0) begin
					send_gap <= $urandom_range(1, 9);
					push <= 1'b0;
				end else begin
					push <= 1'b1;
					coordinate <= coord_queue[0];
				end
			end else begin
				push <= 1'b0;
			end
			if (pop_gap > 0) begin
				pop_gap <= pop_gap - 1;
				pop <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				pop_gap <= $urandom_range(1, 9);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (sigma_queue.size() == 0) begin
				$error("unexpected sigma %0d", sigma);
				errors++;
			end else begin
				if (sigma !== sigma_queue[0]) begin
					$error("sigma: expected %0d, actual %0d", sigma_queue[0], sigma);
					errors++;
				end
				void'(sigma_queue.pop_front());
				sets_done++;
			end
		end
	end

	task automatic wait_drained();
		while (coord_queue.size() > 0 || push || sigma_queue.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MODE) kw_mode = val[MODE_W-1:0];
		else if (idx == REG_VCOUNT) kw_count = val[VCOUNT_W-1:0];
		else if (idx == REG_DIM) kw_dim = val[DIM_W-1:0];
		if (idx <= REG_DIM) restart_set();
		cfg_writes++;
	endtask

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return COORD_W'($urandom_range(0, 15));
			default: return COORD_W'($urandom);
		endcase
	endfunction

	// queue one whole set, or a set with some vectors repeated
	task automatic queue_set(bit repeats);
		int unsigned n, d;
		logic signed [COORD_W-1:0] vec [NDIM];
		n = used_count();
		d = used_dim();
		for (int unsigned v = 0; v < n; v++) begin
			if (!(repeats && v > 0 && $urandom_range(0, 1)))
				for (int unsigned k = 0; k < d; k++) vec[k] = rand_coord();
			for (int unsigned k = 0; k < d; k++) coord_queue.push_back(vec[k]);
		end
	endtask

	initial begin
		int unsigned mode_pick, cnt_pick, dim_pick;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		coordinate = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		sets_done = 0;
		cfg_writes = 0;
		quiet = 0;
		send_gap = 0;
		pop_gap = 0;
		kw_mode = MODE_MEAN;
		kw_count = 7'd64;
		kw_dim = 5'd16;
		foreach (coord_mem[i]) coord_mem[i] = '0;
		restart_set();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: small sets, extreme coordinates, all modes, edge register values
		write_reg(REG_VCOUNT, 7'd0);
		write_reg(REG_DIM, 5'd0);
		for (int m = 0; m < 4; m++) begin
			write_reg(REG_MODE, CFG_DATA_W'(m));
			coord_queue.push_back(16'sh7fff);
			coord_queue.push_back(16'sh8000);
			coord_queue.push_back(16'sh0100);
			coord_queue.push_back(16'sh0100);
			wait_drained();
		end
		write_reg(REG_DIM, 5'd31);
		write_reg(REG_VCOUNT, 7'd2);
		for (int k = 0; k < 16; k++) coord_queue.push_back(16'sh8000);
		for (int k = 0; k < 16; k++) coord_queue.push_back(16'sh7fff);
		wait_drained();
		// abort mid-set, and a write to an unused index
		coord_queue.push_back(16'sh0042);
		wait_drained();
		write_reg(2'd3, 7'h7f);
		write_reg(REG_VCOUNT, 7'd127);
		write_reg(REG_DIM, 5'd1);
		queue_set(0);
		wait_drained();

		// random sets until about 1500 coordinates have been sent
		for (int total = 0; total < 1500;) begin
			mode_pick = $urandom_range(0, 3);
			cnt_pick = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(2, 8);
			dim_pick = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
			write_reg(REG_MODE, CFG_DATA_W'(mode_pick));
			write_reg(REG_VCOUNT, CFG_DATA_W'(cnt_pick));
			write_reg(REG_DIM, CFG_DATA_W'(dim_pick));
			for (int s = 0; s < 4 && total < 1500; s++) begin
				queue_set($urandom_range(0, 3) == 0);
				total += used_count() * used_dim();
			end
			if (total > 1200) quiet = 1;
			wait_drained();
		end

		wait_drained();
		repeat (200) @(posedge clk);
		$display("sets checked: %0d, register writes: %0d, all modes and edge sizes",
			sets_done, cfg_writes);
		if (errors == 0 && sigma_queue.size() == 0) begin
			$display("mean_nearest_neighbour_sigma regression: pass");
		end else begin
			$display("mean_nearest_neighbour_sigma regression: fail");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mnns_pkg.sv
rtl/mnns_isqrt.sv
rtl/mnns_div.sv
rtl/mnns_front.sv
rtl/mnns_fifo.sv
rtl/mnns_back.sv
rtl/mean_nearest_neighbour_sigma.sv
bench/tb_mean_nearest_neighbour_sigma.sv
